[rtl/cdsm_pkg.sv]
package cdsm_pkg;

   localparam int ThrW      = 9;
   localparam int ChanW     = 8;
   localparam int SqW       = 2 * ChanW;
   localparam int SumW      = 18;
   localparam int RootW     = 19;
   localparam int SqrtCells = 10;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 9;
   localparam int TblDepth  = 256;

   localparam logic [ChanW-1:0] FullLevel  = 8'd200;
   localparam logic [ThrW-1:0]  ResetLow   = 9'd25;
   localparam logic [ThrW-1:0]  ResetHigh  = 9'd35;
   localparam logic [ChanW-1:0] ResetRefB  = 8'd36;
   localparam logic [ChanW-1:0] ResetRefG  = 8'd52;
   localparam logic [ChanW-1:0] ResetRefR  = 8'd66;
   localparam logic [RootW-1:0] FirstBit   = 19'h40000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LOW_THRESHOLD  = 3'd0,
      CSR_HIGH_THRESHOLD = 3'd1,
      CSR_REF_BLUE       = 3'd2,
      CSR_REF_GREEN      = 3'd3,
      CSR_REF_RED        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [SumW-1:0]  rem;
      logic [RootW-1:0] root;
      logic [RootW-1:0] bitpos;
   } cell_type;

   typedef logic [ChanW-1:0] slope_tbl_type [TblDepth];

   // magnitude of the ramp slope, indexed by high minus low
   function automatic slope_tbl_type build_slope_tbl();
      slope_tbl_type t;
      int q;
      int r;
      for (int d = 0; d < TblDepth; d++) begin
         q = 0;
         r = int'(FullLevel);
         if (d != 0) begin
            while (r >= d) begin
               r = r - d;
               q = q + 1;
            end
         end
         t[d] = q[ChanW-1:0];
      end
      return t;
   endfunction

   localparam slope_tbl_type SlopeTbl = build_slope_tbl();

endpackage

[rtl/cdsm_req_if.sv]
interface cdsm_req_if;
   logic                        valid;
   logic                        ready;
   logic [cdsm_pkg::ChanW-1:0]  blue;
   logic [cdsm_pkg::ChanW-1:0]  green;
   logic [cdsm_pkg::ChanW-1:0]  red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink (input valid, input blue, input green, input red, output ready);
endinterface

[rtl/cdsm_rsp_if.sv]
interface cdsm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cdsm_pkg::ChanW-1:0]  mask_level;

   modport source (output valid, output mask_level, input ready);
   modport sink (input valid, input mask_level, output ready);
endinterface

[rtl/cdsm_sqdist.sv]
module cdsm_sqdist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [cdsm_pkg::ChanW-1:0]    blue,
   input  logic [cdsm_pkg::ChanW-1:0]    green,
   input  logic [cdsm_pkg::ChanW-1:0]    red,
   input  logic [cdsm_pkg::ChanW-1:0]    ref_blue,
   input  logic [cdsm_pkg::ChanW-1:0]    ref_green,
   input  logic [cdsm_pkg::ChanW-1:0]    ref_red,
   output cdsm_pkg::cell_type            out_cell
);

   logic [cdsm_pkg::ChanW-1:0] db, dg, dr;
   logic [cdsm_pkg::SqW-1:0]   sq_b_ff, sq_g_ff, sq_r_ff;
   logic [cdsm_pkg::SqW-1:0]   sq_b_in, sq_g_in, sq_r_in;
   logic                       sq_valid_ff;
   logic [cdsm_pkg::SumW-1:0]  sum_in, sum_ff;
   logic                       sum_valid_ff;

   assign db = (blue  > ref_blue)  ? blue  - ref_blue  : ref_blue  - blue;
   assign dg = (green > ref_green) ? green - ref_green : ref_green - green;
   assign dr = (red   > ref_red)   ? red   - ref_red   : ref_red   - red;

   assign sq_b_in = {{cdsm_pkg::ChanW{1'b0}}, db} * {{cdsm_pkg::ChanW{1'b0}}, db};
   assign sq_g_in = {{cdsm_pkg::ChanW{1'b0}}, dg} * {{cdsm_pkg::ChanW{1'b0}}, dg};
   assign sq_r_in = {{cdsm_pkg::ChanW{1'b0}}, dr} * {{cdsm_pkg::ChanW{1'b0}}, dr};

   assign sum_in = {2'b00, sq_b_ff} + {2'b00, sq_g_ff} + {2'b00, sq_r_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff  <= in_valid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_b_ff <= sq_b_in;
         sq_g_ff <= sq_g_in;
         sq_r_ff <= sq_r_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_cell.valid  = sum_valid_ff;
   assign out_cell.rem    = sum_ff;
   assign out_cell.root   = '0;
   assign out_cell.bitpos = cdsm_pkg::FirstBit;

endmodule

[rtl/cdsm_sqrt_cell.sv]
module cdsm_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  cdsm_pkg::cell_type in_cell,
   output cdsm_pkg::cell_type out_cell
);

   logic [cdsm_pkg::RootW:0] trial;
   logic                     take;
   cdsm_pkg::cell_type       cell_in, cell_ff;

   assign trial = {1'b0, in_cell.root} + {1'b0, in_cell.bitpos};
   assign take  = {{(cdsm_pkg::RootW + 1 - cdsm_pkg::SumW){1'b0}}, in_cell.rem} >= trial;

   always_comb begin
      cell_in        = in_cell;
      cell_in.bitpos = in_cell.bitpos >> 2;
      if (take) begin
         cell_in.rem  = in_cell.rem - trial[cdsm_pkg::SumW-1:0];
         cell_in.root = (in_cell.root >> 1) + in_cell.bitpos;
      end else begin
         cell_in.root = in_cell.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule

[rtl/cdsm_level.sv]
module cdsm_level (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cdsm_pkg::cell_type           in_cell,
   input  logic [cdsm_pkg::ThrW-1:0]    low_threshold,
   input  logic [cdsm_pkg::ThrW-1:0]    high_threshold,
   output logic                         out_valid,
   output logic [cdsm_pkg::ChanW-1:0]   out_level
);

   logic [cdsm_pkg::ThrW-1:0]  distance;
   logic [cdsm_pkg::ThrW:0]    span;
   logic                       full_in, full_ff;
   logic                       zero_in, zero_ff;
   logic [cdsm_pkg::ChanW-1:0] slope_in, slope_ff;
   logic [cdsm_pkg::ChanW-1:0] diff_in, diff_ff;
   logic                       map_valid_ff;
   logic [2*cdsm_pkg::ChanW-1:0] prod;
   logic [cdsm_pkg::ChanW-1:0] level_in, level_ff;
   logic                       valid_ff;

   assign distance = in_cell.root[cdsm_pkg::ThrW-1:0];
   assign full_in  = distance <= low_threshold;
   assign zero_in  = distance > high_threshold;
   assign span     = {1'b0, high_threshold} - {1'b0, low_threshold};
   assign slope_in = (span > {2'b00, cdsm_pkg::FullLevel}) ? '0
                     : cdsm_pkg::SlopeTbl[span[cdsm_pkg::ChanW-1:0]];
   assign diff_in  = distance[cdsm_pkg::ChanW-1:0] - low_threshold[cdsm_pkg::ChanW-1:0];

   assign prod = {{cdsm_pkg::ChanW{1'b0}}, slope_ff} * {{cdsm_pkg::ChanW{1'b0}}, diff_ff};

   always_comb begin
      if (full_ff) begin
         level_in = cdsm_pkg::FullLevel;
      end else if (zero_ff) begin
         level_in = '0;
      end else begin
         level_in = cdsm_pkg::FullLevel - prod[cdsm_pkg::ChanW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (advance) begin
         map_valid_ff <= in_cell.valid;
         valid_ff     <= map_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         full_ff  <= full_in;
         zero_ff  <= zero_in;
         slope_ff <= slope_in;
         diff_ff  <= diff_in;
         level_ff <= level_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_level = level_ff;

endmodule

[rtl/color_distance_soft_mask.sv]
// channel    dir   handshake      payload
// req_chan   in    valid/ready    blue, green, red (8b each)
// rsp_chan   out   valid/ready    mask_level (8b)
// csr_*      in    csr_we         csr_index (3b), csr_wdata (9b)
//
// One request per cycle while the response is not stalled. Stages: two for the squared
// distance, ten square-root cells (one root bit each), two for the level ramp.
// Synchronous active-high reset; valid flags and the configuration registers return to their reset values.
// A stalled response freezes the whole pipeline; req_chan.ready follows it.
module color_distance_soft_mask (
   input  logic                            clock,
   input  logic                            reset,
   cdsm_req_if.sink                        req_chan,
   cdsm_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [cdsm_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [cdsm_pkg::CsrDataW-1:0]   csr_wdata
);

   logic                       advance;
   logic [cdsm_pkg::ThrW-1:0]  low_ff, high_ff;
   logic [cdsm_pkg::ChanW-1:0] ref_b_ff, ref_g_ff, ref_r_ff;
   cdsm_pkg::cell_type         chain [cdsm_pkg::SqrtCells+1];
   logic                       out_valid;
   logic [cdsm_pkg::ChanW-1:0] out_level;

   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= cdsm_pkg::ResetLow;
         high_ff  <= cdsm_pkg::ResetHigh;
         ref_b_ff <= cdsm_pkg::ResetRefB;
         ref_g_ff <= cdsm_pkg::ResetRefG;
         ref_r_ff <= cdsm_pkg::ResetRefR;
      end else if (csr_we) begin
         case (cdsm_pkg::csr_index_type'(csr_index))
            cdsm_pkg::CSR_LOW_THRESHOLD:  low_ff   <= csr_wdata;
            cdsm_pkg::CSR_HIGH_THRESHOLD: high_ff  <= csr_wdata;
            cdsm_pkg::CSR_REF_BLUE:       ref_b_ff <= csr_wdata[cdsm_pkg::ChanW-1:0];
            cdsm_pkg::CSR_REF_GREEN:      ref_g_ff <= csr_wdata[cdsm_pkg::ChanW-1:0];
            cdsm_pkg::CSR_REF_RED:        ref_r_ff <= csr_wdata[cdsm_pkg::ChanW-1:0];
            default: ;
         endcase
      end
   end

   cdsm_sqdist u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .blue      (req_chan.blue),
      .green     (req_chan.green),
      .red       (req_chan.red),
      .ref_blue  (ref_b_ff),
      .ref_green (ref_g_ff),
      .ref_red   (ref_r_ff),
      .out_cell  (chain[0])
   );

   for (genvar i = 0; i < cdsm_pkg::SqrtCells; i++) begin : g_cell
      cdsm_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   cdsm_level u_level (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_cell        (chain[cdsm_pkg::SqrtCells]),
      .low_threshold  (low_ff),
      .high_threshold (high_ff),
      .out_valid      (out_valid),
      .out_level      (out_level)
   );

   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.mask_level = out_level;

endmodule

[bench/tb_color_distance_soft_mask.sv]
module tb_color_distance_soft_mask;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [cdsm_pkg::ThrW-1:0]  low;
      logic [cdsm_pkg::ThrW-1:0]  high;
      logic [cdsm_pkg::ChanW-1:0] ref_b;
      logic [cdsm_pkg::ChanW-1:0] ref_g;
      logic [cdsm_pkg::ChanW-1:0] ref_r;
   } mask_cfg_type;

   typedef struct packed {
      logic [cdsm_pkg::ChanW-1:0] blue;
      logic [cdsm_pkg::ChanW-1:0] green;
      logic [cdsm_pkg::ChanW-1:0] red;
   } pixel_type;

   typedef struct packed {
      mask_cfg_type               cfg;
      pixel_type                  px;
      logic                       known;
      logic [cdsm_pkg::ChanW-1:0] level;
   } directed_row_type;

   typedef struct {
      logic [cdsm_pkg::ChanW-1:0] level;
      int                         seq;
   } pending_level_type;

   typedef logic [cdsm_pkg::CsrIdxW-1:0] csr_idx_type;

   localparam int RandomPhases  = 12;
   localparam int PhaseItems    = 160;
   localparam int IdlePct       = 19;
   localparam int DrainCycles   = 20;
   localparam int RspHoldCycles = 400;
   localparam int ReportCap     = 10;
   localparam int DirectedCount = 21;

   localparam mask_cfg_type CfgReset     = '{cdsm_pkg::ResetLow, cdsm_pkg::ResetHigh,
                                             cdsm_pkg::ResetRefB, cdsm_pkg::ResetRefG,
                                             cdsm_pkg::ResetRefR};
   localparam mask_cfg_type CfgWide      = '{9'd0, 9'd441, 8'd0, 8'd0, 8'd0};
   localparam mask_cfg_type CfgSteep     = '{9'd0, 9'd1, 8'd255, 8'd255, 8'd255};
   localparam mask_cfg_type CfgInverted  = '{9'd10, 9'd5, 8'd100, 8'd100, 8'd100};
   localparam mask_cfg_type CfgOverRange = '{9'd511, 9'd511, 8'd128, 8'd128, 8'd128};
   localparam mask_cfg_type CfgTallHigh  = '{9'd3, 9'd510, 8'd128, 8'd128, 8'd128};
   localparam mask_cfg_type CfgTruncated = '{9'd0, 9'd3, 8'd100, 8'd100, 8'd100};

   // known = 1: level is the expected mask byte; otherwise the predictor decides
   localparam directed_row_type DirectedRows [DirectedCount] = '{
      '{CfgReset,     '{8'd36,  8'd52,  8'd66},  1'b1, 8'd200},
      '{CfgReset,     '{8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
      '{CfgReset,     '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd0},
      '{CfgReset,     '{8'd61,  8'd52,  8'd66},  1'b1, 8'd200},
      '{CfgReset,     '{8'd62,  8'd52,  8'd66},  1'b0, 8'd0},
      '{CfgReset,     '{8'd71,  8'd52,  8'd66},  1'b0, 8'd0},
      '{CfgReset,     '{8'd72,  8'd52,  8'd66},  1'b1, 8'd0},
      '{CfgWide,      '{8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{CfgWide,      '{8'd0,   8'd0,   8'd0},   1'b1, 8'd200},
      '{CfgSteep,     '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd200},
      '{CfgSteep,     '{8'd254, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{CfgSteep,     '{8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
      '{CfgInverted,  '{8'd110, 8'd100, 8'd100}, 1'b1, 8'd200},
      '{CfgInverted,  '{8'd111, 8'd100, 8'd100}, 1'b1, 8'd0},
      '{CfgInverted,  '{8'd100, 8'd100, 8'd100}, 1'b1, 8'd200},
      '{CfgOverRange, '{8'd0,   8'd0,   8'd0},   1'b1, 8'd200},
      '{CfgOverRange, '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd200},
      '{CfgTallHigh,  '{8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{CfgTruncated, '{8'd103, 8'd100, 8'd100}, 1'b0, 8'd0},
      '{CfgTruncated, '{8'd101, 8'd100, 8'd100}, 1'b0, 8'd0},
      '{CfgTruncated, '{8'd102, 8'd101, 8'd100}, 1'b0, 8'd0}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [cdsm_pkg::CsrIdxW-1:0]  csr_index;
   logic [cdsm_pkg::CsrDataW-1:0] csr_wdata;

   cdsm_req_if req_chan ();
   cdsm_rsp_if rsp_chan ();

   color_distance_soft_mask uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mask_cfg_type      live_cfg;
   mask_cfg_type      target_cfg;
   pending_level_type pending_levels [$];
   int                pixels_sent;
   int                levels_seen;
   int                band_hits;
   int                settings_used;
   int                stall_cycles;
   int                mismatches;
   bit                steady_flow;
   bit                hold_rsp;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [cdsm_pkg::ChanW-1:0] clamp8(input int v);
      if (v < 0) return '0;
      if (v > 255) return '1;
      return 8'(v);
   endfunction

   function automatic logic [cdsm_pkg::ChanW-1:0] step_away(
      input logic [cdsm_pkg::ChanW-1:0] base, input int d);
      return (int'(base) + d <= 255) ? 8'(int'(base) + d) : clamp8(int'(base) - d);
   endfunction

   // mask byte for one pixel under the current register copy
   function automatic logic [cdsm_pkg::ChanW-1:0] mask_for(input pixel_type p,
                                                           output bit in_band);
      int db;
      int dg;
      int dr;
      int sq;
      int distance;
      int lo;
      int hi;
      int slope;
      int ramp;
      db = int'(p.blue) - int'(live_cfg.ref_b);
      dg = int'(p.green) - int'(live_cfg.ref_g);
      dr = int'(p.red) - int'(live_cfg.ref_r);
      sq = db * db + dg * dg + dr * dr;
      distance = 0;
      for (int s = 8; s >= 0; s--) begin
         if ((distance + (1 << s)) * (distance + (1 << s)) <= sq) distance += 1 << s;
      end
      lo = int'(live_cfg.low);
      hi = int'(live_cfg.high);
      in_band = 1'b0;
      if (distance <= lo) return cdsm_pkg::FullLevel;
      if (distance > hi) return '0;
      in_band = 1'b1;
      slope = int'(cdsm_pkg::FullLevel) / (lo - hi);
      ramp = int'(cdsm_pkg::FullLevel) + slope * (distance - lo);
      return ramp[cdsm_pkg::ChanW-1:0];
   endfunction

   task automatic write_reg(input logic [cdsm_pkg::CsrIdxW-1:0] idx,
                            input logic [cdsm_pkg::CsrDataW-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         cdsm_pkg::CSR_LOW_THRESHOLD:  live_cfg.low = data;
         cdsm_pkg::CSR_HIGH_THRESHOLD: live_cfg.high = data;
         cdsm_pkg::CSR_REF_BLUE:       live_cfg.ref_b = data[cdsm_pkg::ChanW-1:0];
         cdsm_pkg::CSR_REF_GREEN:      live_cfg.ref_g = data[cdsm_pkg::ChanW-1:0];
         cdsm_pkg::CSR_REF_RED:        live_cfg.ref_r = data[cdsm_pkg::ChanW-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // drain, then rewrite every register; also poke an unused index
   task automatic load_config(input mask_cfg_type c);
      csr_idx_type spare_idx;
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_levels.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      write_reg(cdsm_pkg::CSR_LOW_THRESHOLD, c.low);
      write_reg(cdsm_pkg::CSR_HIGH_THRESHOLD, c.high);
      write_reg(cdsm_pkg::CSR_REF_BLUE, {1'($urandom), c.ref_b});
      write_reg(cdsm_pkg::CSR_REF_GREEN, {1'($urandom), c.ref_g});
      write_reg(cdsm_pkg::CSR_REF_RED, {1'($urandom), c.ref_r});
      spare_idx = csr_idx_type'($urandom_range((1 << cdsm_pkg::CsrIdxW) - 1,
                                               int'(cdsm_pkg::CSR_REF_RED) + 1));
      write_reg(spare_idx, 9'($urandom));
      csr_we = 1'b0;
      target_cfg = c;
      settings_used++;
   endtask

   task automatic send_pixel(input pixel_type p, input logic known,
                             input logic [cdsm_pkg::ChanW-1:0] level);
      pending_level_type e;
      bit band;
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IdlePct) begin
         req_chan.valid = 1'b0;
         req_chan.blue = 8'($urandom);
         req_chan.green = 8'($urandom);
         req_chan.red = 8'($urandom);
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.blue = p.blue;
      req_chan.green = p.green;
      req_chan.red = p.red;
      do @(posedge clock); while (!req_chan.ready);
      e.level = mask_for(p, band);
      if (known) e.level = level;
      e.seq = pixels_sent;
      pending_levels.push_back(e);
      pixels_sent++;
      if (band) band_hits++;
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            hold_left = RspHoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = steady_flow || $urandom_range(99) >= IdlePct;
         end
      end
   end

   always @(posedge clock) begin
      pending_level_type e;
      if (!reset) begin
         if (req_chan.valid && !req_chan.ready) stall_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_levels.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportCap)
                  $display("unexpected mask byte %0d with nothing pending", rsp_chan.mask_level);
            end else begin
               e = pending_levels.pop_front();
               if (rsp_chan.mask_level !== e.level) begin
                  mismatches++;
                  if (mismatches <= ReportCap)
                     $display("pixel %0d: mask_level expected %0d, got %0d",
                              e.seq, e.level, rsp_chan.mask_level);
               end
            end
            levels_seen++;
         end
      end
   end

   initial begin
      #400_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      mask_cfg_type c;
      pixel_type    p;
      int           mode;
      int           reach;
      int           d;
      int           lo;
      int           hi;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.blue = '0;
      req_chan.green = '0;
      req_chan.red = '0;
      steady_flow = 1'b0;
      hold_rsp = 1'b0;
      pixels_sent = 0;
      levels_seen = 0;
      band_hits = 0;
      stall_cycles = 0;
      mismatches = 0;
      settings_used = 1;
      live_cfg = CfgReset;
      target_cfg = CfgReset;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DirectedCount; i++) begin
         if (DirectedRows[i].cfg != target_cfg) load_config(DirectedRows[i].cfg);
         send_pixel(DirectedRows[i].px, DirectedRows[i].known, DirectedRows[i].level);
      end

      for (int ph = 0; ph < RandomPhases; ph++) begin
         c.ref_b = 8'($urandom);
         c.ref_g = 8'($urandom);
         c.ref_r = 8'($urandom);
         if (ph == 0) begin
            c.ref_b = '0; c.ref_g = '0; c.ref_r = '0;
         end else if (ph == 1) begin
            c.ref_b = '1; c.ref_g = '1; c.ref_r = '1;
         end
         case ($urandom_range(7))
            0: begin  // inverted or equal thresholds
               c.low = 9'($urandom_range(200));
               c.high = 9'($urandom_range(int'(c.low)));
            end
            1: begin  // band wider than 200, slope truncates to zero
               c.low = 9'($urandom_range(200));
               c.high = c.low + 9'($urandom_range(300, 201));
            end
            2: begin
               c.low = $urandom_range(1) ? '1 : '0;
               c.high = $urandom_range(1) ? '1 : '0;
            end
            default: begin
               c.low = 9'($urandom_range(150));
               c.high = c.low + 9'($urandom_range(60, 1));
            end
         endcase
         load_config(c);
         steady_flow = (ph == 5);
         for (int n = 0; n < PhaseItems; n++) begin
            if (ph == 2 && n == 40) hold_rsp = 1'b1;
            mode = $urandom_range(9);
            reach = int'(live_cfg.high) + 4;
            if (reach > 255) reach = 255;
            if (mode < 4) begin
               p.blue = 8'($urandom);
               p.green = 8'($urandom);
               p.red = 8'($urandom);
            end else if (mode < 7) begin
               reach = $urandom_range(reach);
               p.blue = clamp8(int'(live_cfg.ref_b) + int'($urandom_range(2 * reach)) - reach);
               p.green = clamp8(int'(live_cfg.ref_g) + int'($urandom_range(2 * reach)) - reach);
               p.red = clamp8(int'(live_cfg.ref_r) + int'($urandom_range(2 * reach)) - reach);
            end else begin
               // one channel off by a distance around the band, clamped to the channel range
               lo = (int'(live_cfg.low) > 441) ? 441 : int'(live_cfg.low);
               hi = (int'(live_cfg.high) + 1 > 441) ? 441 : int'(live_cfg.high) + 1;
               d = $urandom_range(hi, lo);
               p = '{live_cfg.ref_b, live_cfg.ref_g, live_cfg.ref_r};
               case ($urandom_range(2))
                  0: p.blue = step_away(live_cfg.ref_b, d);
                  1: p.green = step_away(live_cfg.ref_g, d);
                  default: p.red = step_away(live_cfg.ref_r, d);
               endcase
            end
            send_pixel(p, 1'b0, '0);
         end
         steady_flow = 1'b0;
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (2 * DrainCycles) @(posedge clock);
      $display("%0d pixels, %0d mask bytes, %0d register settings, %0d in the ramp band",
               pixels_sent, levels_seen, settings_used, band_hits);
      $display("%0d cycles with input stalled, %0d mismatches", stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
